### src/dtsi_pkg.sv
// shared types, constants and the multiply-by-ten helper for the decimal text parser
package dtsi_pkg;

  localparam int CHAR_W        = 8;
  localparam int SCALE_W       = 5;
  localparam int VALUE_W       = 64;
  localparam int MAX_SCALE_DEF = 18;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

  // largest x with x*10 <= 2^63-1
  localparam logic [VALUE_W-1:0] TENTH_LIMIT = 64'd922337203685477580;
  localparam logic [3:0]         LIMIT_LAST_DIGIT = 4'd7;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_MANY  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WHOLE = 2'd1,
    PH_FRAC  = 2'd2
  } phase_t;

  // one finished string on its way through the scaling stages
  typedef struct packed {
    logic               valid;
    logic               negative;
    logic               big;
    status_t            status;
    logic [VALUE_W-1:0] mag;
    logic [SCALE_W-1:0] k;
  } pipe_t;

  typedef struct packed {
    logic               over;
    logic [VALUE_W-1:0] val;
  } mac10_t;

  // x*10 + d, with a flag for a true result above 2^63-1
  function automatic mac10_t mac10(input logic [VALUE_W-1:0] x, input logic [3:0] d);
    mac10_t r;
    r.over = (x > TENTH_LIMIT) || ((x == TENTH_LIMIT) && (d > LIMIT_LAST_DIGIT));
    r.val  = {x[VALUE_W-4:0], 3'b000} + {x[VALUE_W-2:0], 1'b0} +
             {{(VALUE_W-4){1'b0}}, d};
    return r;
  endfunction

endpackage

### src/dtsi_if.sv
// handshake channels: text characters, parsed results and the scale register write
interface dtsi_text_if;
  import dtsi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              end_of_text;
  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface dtsi_result_if;
  import dtsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

interface dtsi_cfg_if;
  import dtsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] scale;
  modport source (output valid, output scale, input ready);
  modport sink   (input valid, input scale, output ready);
endinterface

### src/dtsi_scale_pipe.sv
// multiply-by-ten stages that bring a parsed digit string up to the declared scale
module dtsi_scale_pipe #(
  parameter int MAX_SCALE = dtsi_pkg::MAX_SCALE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dtsi_pkg::pipe_t entry,
  output logic           advance,
  dtsi_result_if.source  result
);
  import dtsi_pkg::*;

  pipe_t              stage      [0:MAX_SCALE];
  pipe_t              stage_next [1:MAX_SCALE];
  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;
  status_t            fin_status;
  logic [VALUE_W-1:0] fin_value;

  // hold only when a result is ready to leave and the output register is still full
  assign advance = !(stage[MAX_SCALE].valid && out_valid && !result.ready);

  always_comb begin
    mac10_t m;
    for (int i = 0; i < MAX_SCALE; i++) begin
      stage_next[i+1] = stage[i];
      m = mac10(stage[i].mag, 4'd0);
      if ((SCALE_W'(i) < stage[i].k) && !stage[i].big) begin
        if (m.over) begin
          stage_next[i+1].big = 1'b1;
        end else begin
          stage_next[i+1].mag = m.val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_SCALE; i++) begin
        stage[i].valid <= 1'b0;
      end
    end else if (advance) begin
      stage[0] <= entry;
      for (int i = 1; i <= MAX_SCALE; i++) begin
        stage[i] <= stage_next[i];
      end
    end
  end

  always_comb begin
    fin_status = stage[MAX_SCALE].status;
    if (fin_status == ST_OK && stage[MAX_SCALE].big) begin
      fin_status = ST_OVERFLOW;
    end
    fin_value = '0;
    if (fin_status == ST_OK) begin
      fin_value = stage[MAX_SCALE].negative ? (VALUE_W'(0) - stage[MAX_SCALE].mag)
                                            : stage[MAX_SCALE].mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage[MAX_SCALE].valid) begin
      out_valid  <= 1'b1;
      out_status <= fin_status;
      out_value  <= fin_value;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid  = out_valid;
  assign result.status = out_status;
  assign result.value  = $signed(out_value);

endmodule

### src/decimal_text_to_scaled_integer.sv
// top level: character parser and result scaling for ascii decimal numbers
// Takes one character item per cycle and keeps accepting while a result waits in the
// output register, until the last scaling stage also holds a finished string; then the
// input stalls until the output register is read. Characters update the parse state at
// the edge that accepts them. The end item is loaded into the first scaling stage at the
// edge that accepts it, passes MAX_SCALE multiply-by-ten stages that scale the digit
// string up to the scale register, and then reaches the output register. The scale register may be
// written whenever no result is pending; values above MAX_SCALE act as MAX_SCALE.
module decimal_text_to_scaled_integer #(
  parameter int MAX_SCALE = dtsi_pkg::MAX_SCALE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dtsi_text_if.sink     text,
  dtsi_result_if.source result,
  dtsi_cfg_if.sink      cfg
);
  import dtsi_pkg::*;

  logic [SCALE_W-1:0] scale;
  phase_t             phase,    phase_next;
  logic               negative, negative_next;
  logic [VALUE_W-1:0] acc,      acc_next;
  logic               big,      big_next;
  logic               seen,     seen_next;
  logic [SCALE_W-1:0] taken,    taken_next;
  status_t            err,      err_next;

  logic [SCALE_W-1:0] eff_scale;
  logic               advance;
  logic               accept;
  logic [3:0]         digit;
  mac10_t             m;
  pipe_t              entry;
  status_t            end_status;

  assign eff_scale = (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;
  assign text.ready = advance;
  assign accept = text.valid && advance;
  assign cfg.ready = 1'b1;

  assign digit = text.character[3:0] - CH_0[3:0];
  assign m = mac10(acc, digit);

  always_comb begin
    end_status = err;
    if (end_status == ST_OK && !seen && taken == '0) begin
      end_status = ST_MALFORMED;
    end
    if (end_status == ST_OK && taken > eff_scale) begin
      end_status = ST_TOO_MANY;
    end
  end

  always_comb begin
    entry = '0;
    if (text.end_of_text) begin
      entry.valid    = accept;
      entry.negative = negative;
      entry.big      = big;
      entry.status   = end_status;
      entry.mag      = acc;
      entry.k        = eff_scale - taken;
    end
  end

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    big_next      = big;
    seen_next     = seen;
    taken_next    = taken;
    err_next      = err;
    if (text.end_of_text) begin
      phase_next     = PH_START;
      negative_next  = 1'b0;
      acc_next       = '0;
      big_next       = 1'b0;
      seen_next      = 1'b0;
      taken_next     = '0;
      err_next       = ST_OK;
    end else if (text.character inside {[CH_0:CH_9]}) begin
      if (phase == PH_FRAC) begin
        if (taken >= eff_scale) begin
          if (err == ST_OK) err_next = ST_TOO_MANY;
        end else begin
          // the fraction keeps extending the digit string; a big value is only an error at the end
          taken_next = taken + SCALE_W'(1);
          if (!big) begin
            if (m.over) begin
              big_next = 1'b1;
            end else begin
              acc_next = m.val;
            end
          end
        end
      end else begin
        phase_next = PH_WHOLE;
        seen_next  = 1'b1;
        if (m.over) begin
          if (err == ST_OK) err_next = ST_OVERFLOW;
        end else begin
          acc_next = m.val;
        end
      end
    end else if (text.character == CH_PLUS || text.character == CH_MINUS) begin
      if (phase == PH_START) begin
        negative_next = (text.character == CH_MINUS);
        phase_next    = PH_WHOLE;
      end else if (err == ST_OK) begin
        err_next = ST_MALFORMED;
      end
    end else if (text.character == CH_COMMA || text.character == CH_DOT) begin
      if (phase == PH_FRAC) begin
        if (err == ST_OK) err_next = ST_MALFORMED;
      end else begin
        phase_next = PH_FRAC;
      end
    end else if (err == ST_OK) begin
      err_next = ST_MALFORMED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_RESET;
      phase    <= PH_START;
      negative <= 1'b0;
      acc      <= '0;
      big      <= 1'b0;
      seen     <= 1'b0;
      taken    <= '0;
      err      <= ST_OK;
    end else begin
      if (cfg.valid) begin
        scale <= cfg.scale;
      end
      if (accept) begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
        big      <= big_next;
        seen     <= seen_next;
        taken    <= taken_next;
        err      <= err_next;
      end
    end
  end

  dtsi_scale_pipe #(
    .MAX_SCALE (MAX_SCALE)
  ) u_scale_pipe (
    .clk     (clk),
    .rst     (rst),
    .entry   (entry),
    .advance (advance),
    .result  (result)
  );

endmodule

### sim/tb_decimal_text_to_scaled_integer.sv
// testbench for the decimal text parser: directed strings, then random numbers checked by a predictor
module tb_decimal_text_to_scaled_integer;
  timeunit 1ns;
  timeprecision 1ps;

  import dtsi_pkg::*;

  localparam int MAX_SCALE = MAX_SCALE_DEF;
  localparam int PIPE_WAIT = MAX_SCALE + 6;
  localparam int ROUND_ITEMS = 150;
  localparam int ROUNDS = 8;
  localparam logic [VALUE_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
  } parsed_t;

  typedef struct {
    int      scale;     // below zero keeps the current scale
    bit      nul_lead;
    string   text;
    bit      closed;
    bit      typed;
    status_t status;
    longint  value;
  } text_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtsi_text_if   text_ch ();
  dtsi_result_if result_ch ();
  dtsi_cfg_if    cfg_ch ();

  decimal_text_to_scaled_integer #(
    .MAX_SCALE(MAX_SCALE)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  parsed_t expected_results[$];
  int unsigned failures = 0;
  int unsigned burst_left = 0;

  // predictor state
  logic [SCALE_W-1:0] scale_now;
  phase_t             num_phase;
  logic               num_minus;
  logic               num_int_seen;
  logic [VALUE_W-1:0] num_int;
  logic [VALUE_W-1:0] num_frac;
  logic [SCALE_W-1:0] num_frac_cnt;
  status_t            num_err;

  text_case_t cases [19] = '{
    '{-1, 1'b0, "1.5",    1'b1, 1'b1, ST_OK,        150},
    '{-1, 1'b0, "-0",     1'b1, 1'b1, ST_OK,        0},
    '{-1, 1'b0, "",       1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b0, "+.",     1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b0, "1-",     1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b0, "1.2.",   1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b0, "4\377",  1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b1, "5",      1'b1, 1'b1, ST_MALFORMED, 0},
    '{-1, 1'b0, "1.234x", 1'b1, 1'b1, ST_TOO_MANY,  0},
    '{-1, 1'b0, ",75",    1'b1, 1'b1, ST_OK,        75},
    '{-1, 1'b0, "+3.",    1'b1, 1'b0, ST_OK,        0},
    '{0,  1'b0, "9223372036854775807",  1'b1, 1'b1, ST_OK, 64'sd9223372036854775807},
    '{-1, 1'b0, "-9223372036854775808", 1'b1, 1'b1, ST_OVERFLOW, 0},
    '{18, 1'b0, "-9",     1'b1, 1'b1, ST_OK,        -64'sd9000000000000000000},
    '{-1, 1'b0, "10",     1'b1, 1'b1, ST_OVERFLOW,  0},
    '{31, 1'b0, "0.5",    1'b1, 1'b1, ST_OK,        64'sd500000000000000000},
    // string left open, then the scale drops below the digits already taken
    '{6,  1'b0, "-1.2345", 1'b0, 1'b0, ST_OK,       0},
    '{2,  1'b0, "",       1'b1, 1'b1, ST_TOO_MANY,  0},
    '{3,  1'b0, "-07,09", 1'b1, 1'b0, ST_OK,        0}
  };

  function automatic int unsigned eff_scale();
    return (scale_now > MAX_SCALE) ? MAX_SCALE : scale_now;
  endfunction

  function automatic void clear_number();
    num_phase    = PH_START;
    num_minus    = 1'b0;
    num_int_seen = 1'b0;
    num_int      = '0;
    num_frac     = '0;
    num_frac_cnt = '0;
    num_err      = ST_OK;
  endfunction

  // the first error in text order wins
  function automatic void note_error(status_t code);
    if (num_err == ST_OK) num_err = code;
  endfunction

  function automatic logic [VALUE_W-1:0] ten_to(int unsigned n);
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic void parse_char(logic [CHAR_W-1:0] c);
    int unsigned        s;
    logic [VALUE_W-1:0] d;
    s = eff_scale();
    if (c >= CH_0 && c <= CH_9) begin
      d = VALUE_W'(c - CH_0);
      if (num_phase == PH_FRAC) begin
        if (num_frac_cnt >= s) begin
          note_error(ST_TOO_MANY);
        end else begin
          num_frac     = num_frac * 64'd10 + d;
          num_frac_cnt = num_frac_cnt + 1'b1;
        end
      end else begin
        num_phase    = PH_WHOLE;
        num_int_seen = 1'b1;
        if (num_int > (MAG_MAX - d) / 64'd10) note_error(ST_OVERFLOW);
        else num_int = num_int * 64'd10 + d;
      end
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (num_phase == PH_START) begin
        num_minus = (c == CH_MINUS);
        num_phase = PH_WHOLE;
      end else begin
        note_error(ST_MALFORMED);
      end
    end else if (c == CH_COMMA || c == CH_DOT) begin
      if (num_phase == PH_FRAC) note_error(ST_MALFORMED);
      else num_phase = PH_FRAC;
    end else begin
      note_error(ST_MALFORMED);
    end
  endfunction

  function automatic parsed_t close_number();
    parsed_t            r;
    int unsigned        s;
    logic [VALUE_W-1:0] padded, p, mag;
    s = eff_scale();
    r.value = '0;
    if (!num_int_seen && num_frac_cnt == 0) note_error(ST_MALFORMED);
    if (num_frac_cnt > s) note_error(ST_TOO_MANY);
    if (num_err == ST_OK) begin
      padded = num_frac * ten_to(s - num_frac_cnt);
      p      = ten_to(s);
      if (padded > MAG_MAX || num_int > (MAG_MAX - padded) / p) begin
        note_error(ST_OVERFLOW);
      end else begin
        mag     = num_int * p + padded;
        r.value = num_minus ? -mag : mag;
      end
    end
    r.status = num_err;
    if (num_err != ST_OK) r.value = '0;
    clear_number();
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return CH_0 + CHAR_W'($urandom_range(0, 9));
    else if (sel == 5) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    else if (sel == 6) return $urandom_range(0, 1) ? CH_COMMA : CH_DOT;
    else return CHAR_W'($urandom);
  endfunction

  // offer one item in bursts with random gaps, then feed the predictor once it is taken
  task automatic offer(input logic [CHAR_W-1:0] ch, input logic eot);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.character   <= ch;
    text_ch.end_of_text <= eot;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    if (eot) expected_results = {expected_results, close_number()};
    else parse_char(ch);
  endtask

  // scale writes only once the pipeline has drained
  task automatic write_scale(input int v);
    text_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.scale <= SCALE_W'(v);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    scale_now = SCALE_W'(v);
  endtask

  // mostly well-formed numbers, some of them corrupted
  task automatic send_random_number(inout int unsigned sent);
    logic [CHAR_W-1:0] chars[$];
    int unsigned       n_int, n_frac, k;
    bit                has_mark;
    k = eff_scale();
    case ($urandom_range(0, 3))
      0: chars = {chars, CH_PLUS};
      1: chars = {chars, CH_MINUS};
      default: ;
    endcase
    n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
    has_mark = ($urandom_range(0, 2) != 0);
    n_frac = 0;
    if (has_mark) n_frac = ($urandom_range(0, 9) == 0) ? k + 1 : $urandom_range(0, k);
    if (n_int == 0 && n_frac == 0) n_int = 1;
    repeat (n_int) chars = {chars, (CH_0 + CHAR_W'($urandom_range(0, 9)))};
    if (has_mark) chars = {chars, ($urandom_range(0, 1) ? CH_COMMA : CH_DOT)};
    repeat (n_frac) chars = {chars, (CH_0 + CHAR_W'($urandom_range(0, 9)))};
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: if (chars.size() != 0) chars[$urandom_range(0, chars.size() - 1)] = pick_char();
        1: chars.insert($urandom_range(0, chars.size()), pick_char());
        2: if (chars.size() != 0) chars.delete($urandom_range(0, chars.size() - 1));
        default: begin
          chars.delete();
          repeat ($urandom_range(0, 6)) chars = {chars, pick_char()};
        end
      endcase
    end
    foreach (chars[i]) offer(chars[i], 1'b0);
    offer(CHAR_W'($urandom), 1'b1);
    sent += chars.size() + 1;
  endtask

  always @(posedge clk) begin : check_results
    parsed_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d", result_ch.status, result_ch.value);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_ch.status);
          failures++;
        end
        if (result_ch.value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, result_ch.value);
          failures++;
        end
      end
    end
  end

  // receiver: random stall pattern plus a long hold-off now and then
  initial begin : receiver
    logic [15:0] pattern;
    int unsigned cyc, hold_left;
    result_ch.ready <= 1'b0;
    pattern   = 16'hFFFF;
    cyc       = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      if (cyc % 1500 == 1000) hold_left = 400;
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= pattern[cyc % 16];
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int          s;
    text_ch.valid       <= 1'b0;
    text_ch.character   <= '0;
    text_ch.end_of_text <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.scale        <= '0;
    scale_now = SCALE_RESET;
    clear_number();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (cases[i]) begin
      if (cases[i].scale >= 0) write_scale(cases[i].scale);
      if (cases[i].nul_lead) offer(8'h00, 1'b0);
      for (int j = 0; j < cases[i].text.len(); j++) offer(cases[i].text[j], 1'b0);
      if (cases[i].closed) begin
        offer(CHAR_W'($urandom), 1'b1);
        if (cases[i].typed) begin
          expected_results[expected_results.size() - 1] =
            '{status: cases[i].status, value: cases[i].value};
        end
      end
    end

    for (int r = 0; r < ROUNDS; r++) begin
      case (r)
        0: s = 0;
        1: s = 31;
        2: s = MAX_SCALE;
        3: s = 1;
        7: s = 2;
        default: s = $urandom_range(0, 31);
      endcase
      write_scale(s);
      sent = 0;
      while (sent < ROUND_ITEMS) send_random_number(sent);
    end

    text_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("decimal_text_to_scaled_integer test passed");
    end else begin
      $display("decimal_text_to_scaled_integer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("decimal_text_to_scaled_integer test failed");
    $finish;
  end

endmodule

### files.f
src/dtsi_pkg.sv
src/dtsi_if.sv
src/dtsi_scale_pipe.sv
src/decimal_text_to_scaled_integer.sv
sim/tb_decimal_text_to_scaled_integer.sv
